### sv/ps2_mouse_cursor_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication
`define PS2MCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2mct: same-cycle check failed");

// Next-cycle implication
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2mct: next-cycle check failed");

`endif

### sv/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Field widths, register indexes, header masks and the move scaling function.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int TERM_W     = 2;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int SLOT_W     = 2;
  localparam int MOVE_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'b1;

  // Register reset values
  localparam logic [COL_W-1:0] COLS_RESET = 7'd80;
  localparam logic [ROW_W-1:0] ROWS_RESET = 5'd25;

  // Packet byte slots
  localparam logic [SLOT_W-1:0] SLOT_HDR = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_DX  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_DY  = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_BAD = 2'd3;

  // Header bits: overflow Y/X (7,6) and the always-one bit (3)
  localparam logic [BYTE_W-1:0] HDR_SYNC_MASK = 8'hC8;
  localparam logic [BYTE_W-1:0] HDR_OVF_MASK  = 8'hC0;

  // Two's complement byte divided by ten, truncated toward zero.
  // Magnitude is at most 128, so (m * 205) >> 11 is exact.
  function automatic logic signed [MOVE_W-1:0] scaled_move(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] mag;
    logic [15:0]       prod;
    logic [MOVE_W-1:0] q;
    mag  = b[BYTE_W-1] ? (~b + 8'd1) : b;
    prod = 16'(mag) * 16'd205;
    q    = prod[15:11];
    return b[BYTE_W-1] ? $signed(-q) : $signed(q);
  endfunction

endpackage

### sv/ps2_mouse_cursor_tracker_unit.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Assembles 3-byte mouse packets and moves a per-terminal text cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one mouse byte and the
//   active terminal index per word. Every third byte of a packet yields one
//   result word on the output channel (out_valid_o / out_stall_i) with the
//   old and new cursor position and a dropped flag for overflow packets.
//   Other bytes yield nothing.
//   A packet's last byte waits in the input register, and the result
//   register loads the result word from it once that register is free.
//   Throughput: one byte per cycle while no stalled result is held; the
//   whole packet step is one pass of logic between the input register and
//   the result register. A full result register that is stalled holds its
//   word; the input register then fills and in_stall_o rises until the
//   result is taken. Reset clears the packet bytes, the slot counter and
//   all cursors, and loads 80 columns and 25 rows. The user writes the
//   limits through the cfg_we_i / cfg_idx_i / cfg_data_i port only while
//   the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "ps2_mouse_cursor_tracker_unit_macros.svh"

module ps2_mouse_cursor_tracker_unit #(
  parameter int TERMINALS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // byte input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ps2mct_pkg::BYTE_W-1:0]      rx_byte_i,
  input  logic [ps2mct_pkg::TERM_W-1:0]      terminal_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               dropped_o,
  output logic [ps2mct_pkg::COL_W-1:0]       old_x_o,
  output logic [ps2mct_pkg::ROW_W-1:0]       old_y_o,
  output logic [ps2mct_pkg::COL_W-1:0]       new_x_o,
  output logic [ps2mct_pkg::ROW_W-1:0]       new_y_o
);
  import ps2mct_pkg::*;

  localparam int TermIdxW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  // Configuration registers
  logic [COL_W-1:0] cols_q;
  logic [ROW_W-1:0] rows_q;

  // Input register
  logic              s1_valid_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic [TERM_W-1:0] s1_term_q;

  // Packet state: the last byte is used straight from the input register
  logic [BYTE_W-1:0] pkt0_q, pkt1_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] slot_eff;
  logic [COL_W-1:0]  cur_col_q [TERMINALS];
  logic [ROW_W-1:0]  cur_row_q [TERMINALS];

  // Result register
  logic             out_valid_q;
  logic             dropped_q;
  logic [COL_W-1:0] old_x_q, new_x_q;
  logic [ROW_W-1:0] old_y_q, new_y_q;

  // Step logic
  logic                     out_free;
  logic                     fire;
  logic                     completes;
  logic                     overflow;
  logic                     term_ok;
  logic [TermIdxW-1:0]      term_idx;
  logic [COL_W-1:0]         ox, nx;
  logic [ROW_W-1:0]         oy, ny;
  logic signed [MOVE_W-1:0] dx, dy;
  logic signed [COL_W+1:0]  tx;
  logic signed [ROW_W+1:0]  ty;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_COLS: cols_q <= cfg_data_i;
        CFG_SCREEN_ROWS: rows_q <= ROW_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= rx_byte_i;
      s1_term_q <= terminal_i;
    end
  end

  // Slot selection with resync on a header lacking the sync bits or on SLOT_BAD
  always_comb begin
    if ((pkt0_q & HDR_SYNC_MASK) == '0 || slot_q == SLOT_BAD) begin
      slot_eff = SLOT_HDR;
    end else begin
      slot_eff = slot_q;
    end
    completes = (slot_eff == SLOT_DY);
    slot_d    = completes ? SLOT_HDR : slot_eff + 2'd1;
  end

  // Packet evaluation: header and dx stored, dy is the incoming byte
  always_comb begin
    overflow = (pkt0_q & HDR_OVF_MASK) != '0;
    term_ok  = 32'(s1_term_q) < TERMINALS;
    term_idx = TermIdxW'(s1_term_q);
    dx       = scaled_move(pkt1_q);
    dy       = scaled_move(s1_byte_q);
    ox       = '0;
    oy       = '0;
    if (term_ok) begin
      ox = cur_col_q[term_idx];
      oy = cur_row_q[term_idx];
    end
    tx = $signed({2'b00, ox}) + $signed({{4{dx[MOVE_W-1]}}, dx});
    ty = $signed({2'b00, oy}) - $signed({{2{dy[MOVE_W-1]}}, dy});
    nx = ox;
    ny = oy;
    if (term_ok && !overflow) begin
      if (!tx[COL_W+1] && tx[COL_W:0] < {1'b0, cols_q}) nx = tx[COL_W-1:0];
      if (!ty[ROW_W+1] && ty[ROW_W:0] < {1'b0, rows_q}) ny = ty[ROW_W-1:0];
    end
  end

  // Packet bytes and slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt0_q <= '0;
      pkt1_q <= '0;
      slot_q <= SLOT_HDR;
    end else if (fire) begin
      slot_q <= slot_d;
      unique case (slot_eff)
        SLOT_HDR: pkt0_q <= s1_byte_q;
        SLOT_DX:  pkt1_q <= s1_byte_q;
        SLOT_DY:  ;
        default:  pkt0_q <= s1_byte_q;
      endcase
    end
  end

  // Cursor store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TERMINALS; i++) begin
        cur_col_q[i] <= '0;
        cur_row_q[i] <= '0;
      end
    end else if (fire && completes && term_ok && !overflow) begin
      cur_col_q[term_idx] <= nx;
      cur_row_q[term_idx] <= ny;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && completes) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && completes) begin
      dropped_q <= overflow;
      old_x_q   <= ox;
      old_y_q   <= oy;
      new_x_q   <= nx;
      new_y_q   <= ny;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dropped_o   = dropped_q;
  assign old_x_o     = old_x_q;
  assign old_y_o     = old_y_q;
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;

  // Checks
  `PS2MCT_ASSERT_NEXT(a_result_follows_packet, fire && completes, out_valid_q)
  `PS2MCT_ASSERT_NOW(a_dropped_no_move, out_valid_q && dropped_q, old_x_q == new_x_q && old_y_q == new_y_q)
  `PS2MCT_ASSERT_NEXT(a_col_move_in_range, fire && completes && nx != ox, new_x_q < cols_q)
  `PS2MCT_ASSERT_NEXT(a_row_move_in_range, fire && completes && ny != oy, new_y_q < rows_q)

endmodule
